>>> hw/rtl/lrk4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrk4_pkg
// Shared types and constants for the Lorenz RK4 integrator.
// ----------------------------------------------------------------------------
package lrk4_pkg;

    localparam int FRAC_BITS = 20;
    localparam int WORD_W    = 32;
    localparam int H_W       = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam longint SIGMA_RAW = longint'(10) <<< FRAC_BITS;
    localparam longint RHO_RAW   = longint'(28) <<< FRAC_BITS;
    localparam longint BETA_RAW  = (2 * (longint'(8) <<< FRAC_BITS) + 3) / 6;
    localparam longint STEP_RAW  = (2 * (longint'(1) <<< FRAC_BITS) + 10) / 20;

    localparam longint WMAX = 64'sd2147483647;
    localparam logic signed [WORD_W-1:0] SIGMA_RST =
        (SIGMA_RAW > WMAX) ? WORD_W'(WMAX) : WORD_W'(SIGMA_RAW);
    localparam logic signed [WORD_W-1:0] RHO_RST =
        (RHO_RAW > WMAX) ? WORD_W'(WMAX) : WORD_W'(RHO_RAW);
    localparam logic signed [WORD_W-1:0] BETA_RST =
        (BETA_RAW > WMAX) ? WORD_W'(WMAX) : WORD_W'(BETA_RAW);
    localparam logic [H_W-1:0] STEP_RST = H_W'(STEP_RAW);

    // reciprocal of 6 for 34-bit magnitudes: ceil(2^37/6)
    localparam logic [35:0] RECIP6 = 36'd22906492246;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_DIVFIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                      op;
        logic signed [WORD_W-1:0]  load_x;
        logic signed [WORD_W-1:0]  load_y;
        logic signed [WORD_W-1:0]  load_z;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  state_x;
        logic signed [WORD_W-1:0]  state_y;
        logic signed [WORD_W-1:0]  state_z;
        logic        [WORD_W-1:0]  steps_taken;
        logic                      saturated;
    } out_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/lrk4_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrk4_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface lrk4_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lorenz_rk4_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lorenz_rk4_integrator
// Lorenz system integrator, one RK4 step per transaction, shared multiplier.
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_ch     in    op, load_x, load_y, load_z
// out_ch    out   state_x, state_y, state_z, steps_taken, saturated
// cfg       in    cfg_we, cfg_idx, cfg_data
//
// A load goes to the output state once accepted; a step first forms 32
// products through the single 32x32 multiplier, each with a multiply and an
// accumulate state, then three divisions by six, each with a DIV and a DIVFIX
// state, and then enters the output state. in_ch is ready again as the result appears.
// Reset clears state and counter and restores the default coefficients.
// Hold in the output state while an earlier result still waits on out_ch.
// ----------------------------------------------------------------------------
module lorenz_rk4_integrator
    import lrk4_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [WORD_W-1:0]     cfg_data,
    lrk4_if.sink                       in_ch,
    lrk4_if.source                     out_ch
);

    logic signed [WORD_W-1:0] sigma_reg, beta_reg, rho_reg;
    logic        [H_W-1:0]    h_reg;
    logic signed [WORD_W-1:0] s_reg [3];
    logic signed [WORD_W-1:0] t_reg [3];
    logic signed [WORD_W-1:0] k_reg [3];
    logic signed [35:0]       sum_reg [3];
    logic signed [WORD_W-1:0] p1_reg, p2_reg;
    logic        [WORD_W-1:0] cnt_reg;
    logic                     sat_reg;
    state_t                   state_reg, state_next;
    logic [5:0]               pc_reg, pc_next;
    logic [1:0]               stage_reg, stage_next;
    logic signed [63:0]       prod_reg;
    logic [71:0]              dprod_reg;
    logic                     dneg_reg;
    logic [34:0]              dmag_reg;
    logic [1:0]               dlane_reg;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    // kinds: 0 d=sig*(y-x); 1 p1=rho*x; 2 d=p1-y-x*z; 3 p2=x*y; 4 d=p2-beta*z

    logic signed [WORD_W-1:0] ev [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ev[i] = (stage_reg == 2'd0) ? s_reg[i] : t_reg[i];
        end
    end

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v,
                                                       output logic f);
        f = 1'b0;
        if (v > 66'sd2147483647)
        begin
            f = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -66'sd2147483648)
        begin
            f = 1'b1;
            return 32'sh80000000;
        end
        return v[WORD_W-1:0];
    endfunction

    // Phase counter pc: 0..4 derivative products, 5..7 trial/update products.
    logic signed [WORD_W-1:0] ma, mb;
    logic signed [WORD_W-1:0] yx_diff;
    logic                     yx_sat;
    logic [1:0]               lane;
    always_comb
    begin
        yx_diff = sat32(66'(ev[1]) - 66'(ev[0]), yx_sat);
        lane    = 2'(pc_reg - 6'd5);
        ma      = '0;
        mb      = '0;
        unique case (pc_reg)
            6'd0:    begin ma = sigma_reg; mb = yx_diff; end
            6'd1:    begin ma = rho_reg;   mb = ev[0];   end
            6'd2:    begin ma = ev[0];     mb = ev[2];   end
            6'd3:    begin ma = ev[0];     mb = ev[1];   end
            6'd4:    begin ma = beta_reg;  mb = ev[2];   end
            default: begin ma = k_reg[lane]; mb = {1'b0, h_reg}; end
        endcase
    end

    logic        half;
    logic [5:0]  sh;
    logic signed [64:0] rq;
    logic signed [WORD_W-1:0] rp;
    logic        rp_sat;
    always_comb
    begin
        half = (stage_reg == 2'd0 || stage_reg == 2'd1) && pc_reg >= 6'd5;
        sh   = 6'(FRAC_BITS) + {5'd0, half};
        rq   = (65'(prod_reg) + (65'sd1 <<< (sh - 6'd1))) >>> sh;
        rp   = sat32(66'(rq), rp_sat);
    end

    // division of sum by six, rounded half away from zero
    logic [34:0] dabs;
    logic [35:0] dnum;
    logic [36:0] qd;
    always_comb
    begin
        dabs = sum_reg[dlane_reg][35] ? 35'(-sum_reg[dlane_reg]) : 35'(sum_reg[dlane_reg]);
        dnum = {1'b0, dabs} + 36'd3;
        qd   = 37'(dprod_reg >> 37);
    end

    logic signed [WORD_W-1:0] rx_val, k1_val, k2_val, upd_val, avg_mag, avg_val;
    logic                     f_rx, f_k1, f_k2, f_upd, acc_sat;
    always_comb
    begin
        rx_val  = sat32(66'(p1_reg) - 66'(ev[1]), f_rx);
        k1_val  = sat32(66'(rx_val) - 66'(rp), f_k1);
        k2_val  = sat32(66'(p2_reg) - 66'(rp), f_k2);
        upd_val = sat32(66'(s_reg[lane]) + 66'(rp), f_upd);
        avg_mag = (37'(qd) * 37'd6 > 37'(dmag_reg)) ? 32'(qd - 37'd1) : 32'(qd);
        avg_val = dneg_reg ? -avg_mag : avg_mag;
        acc_sat = rp_sat;
        if (pc_reg == 6'd2)
        begin
            acc_sat = rp_sat | f_rx | f_k1;
        end
        else if (pc_reg == 6'd4)
        begin
            acc_sat = rp_sat | f_k2;
        end
        else if (pc_reg >= 6'd5)
        begin
            acc_sat = rp_sat | f_upd;
        end
    end

    logic in_acc;
    logic out_fire;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_fire    = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        stage_next = stage_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.data.op == OP_STEP)
                begin
                    state_next = ST_MUL;
                    pc_next    = '0;
                    stage_next = '0;
                end
                else if (in_acc)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (stage_reg == 2'd3 && pc_reg >= 6'd5)
                begin
                    state_next = (pc_reg == 6'd7) ? ST_OUT : ST_DIV;
                end
                else if (pc_reg == 6'd7)
                begin
                    pc_next    = '0;
                    stage_next = stage_reg + 2'd1;
                    state_next = ST_MUL;
                end
                else
                begin
                    pc_next    = pc_reg + 6'd1;
                    state_next = (pc_reg == 6'd4 && stage_reg == 2'd3) ? ST_DIV : ST_MUL;
                end
            end
            ST_DIV:
            begin
                state_next = ST_DIVFIX;
            end
            ST_DIVFIX:
            begin
                pc_next    = 6'd5 + 6'(dlane_reg);
                state_next = ST_MUL;
            end
            ST_OUT:
            begin
                state_next = out_fire ? ST_IDLE : ST_OUT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stage 3: after k4 (pc 0..4), per lane: DIV, DIVFIX (k=avg), MUL(pc 5+lane), ACC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            stage_reg     <= '0;
            dlane_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            sigma_reg     <= SIGMA_RST;
            beta_reg      <= BETA_RST;
            rho_reg       <= RHO_RST;
            h_reg         <= STEP_RST;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            prod_reg      <= '0;
            dprod_reg     <= '0;
            dneg_reg      <= 1'b0;
            dmag_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                s_reg[i]   <= '0;
                t_reg[i]   <= '0;
                k_reg[i]   <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            stage_reg <= stage_next;
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_SIGMA: sigma_reg <= cfg_data;
                    CFG_BETA:  beta_reg  <= cfg_data;
                    CFG_RHO:   rho_reg   <= cfg_data;
                    CFG_STEP:  h_reg     <= cfg_data[H_W-1:0];
                    default:   ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_ch.data.op == OP_LOAD)
                    begin
                        s_reg[0] <= in_ch.data.load_x;
                        s_reg[1] <= in_ch.data.load_y;
                        s_reg[2] <= in_ch.data.load_z;
                        cnt_reg  <= '0;
                        sat_reg  <= 1'b0;
                    end
                    else if (in_acc)
                    begin
                        sat_reg   <= 1'b0;
                        dlane_reg <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg <= 64'(ma) * 64'(mb);
                    if (pc_reg == 6'd0 && yx_sat)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                ST_ACC:
                begin
                    if (acc_sat)
                    begin
                        sat_reg <= 1'b1;
                    end
                    unique case (pc_reg)
                        6'd0: k_reg[0] <= rp;
                        6'd1: p1_reg   <= rp;
                        6'd2: k_reg[1] <= k1_val;
                        6'd3: p2_reg   <= rp;
                        6'd4:
                        begin
                            k_reg[2] <= k2_val;
                            for (int i = 0; i < 3; i++)
                            begin
                                sum_reg[i] <= sum_reg[i] + ((stage_reg == 2'd1 ||
                                    stage_reg == 2'd2) ? 36'(i == 2 ? k2_val : k_reg[i]) <<< 1
                                    : 36'(i == 2 ? k2_val : k_reg[i]));
                            end
                            dlane_reg <= '0;
                        end
                        default:
                        begin
                            if (stage_reg == 2'd3)
                            begin
                                s_reg[lane] <= upd_val;
                                dlane_reg   <= dlane_reg + 2'd1;
                                if (lane == 2'd2)
                                begin
                                    cnt_reg <= cnt_reg + 32'd1;
                                end
                            end
                            else
                            begin
                                t_reg[lane] <= upd_val;
                            end
                        end
                    endcase
                end
                ST_DIV:
                begin
                    dneg_reg  <= sum_reg[dlane_reg][35];
                    dmag_reg  <= dnum[34:0];
                    dprod_reg <= 72'(dnum) * 72'(RECIP6);
                end
                ST_DIVFIX:
                begin
                    k_reg[dlane_reg] <= avg_val;
                end
                ST_OUT:
                begin
                    if (out_fire)
                    begin
                        out_reg.state_x     <= s_reg[0];
                        out_reg.state_y     <= s_reg[1];
                        out_reg.state_z     <= s_reg[2];
                        out_reg.steps_taken <= cnt_reg;
                        out_reg.saturated   <= sat_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result dropped or changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> out_valid_reg)
        else $error("result not presented");

endmodule
`default_nettype wire
